// ----- design/fft_pkg.sv -----
// Package for the radix-2 FFT engine: widths, constants and the twiddle ROM.
// No dependencies.
package fft_pkg;

  localparam int MaxLog2 = 6;
  localparam int MaxPoints = 64;
  localparam int SampleBits = 16;
  localparam int TwBits = 16;
  localparam int OutBits = 22;
  localparam int AddrBits = 6;
  localparam int WordBits = 2 * OutBits;

  // Quarter sine, Q1.23, 17 entries
  function automatic logic signed [24:0] qsine(input logic [4:0] idx);
    logic signed [24:0] v;
    case (idx)
      5'd0: v = 25'sd0;
      5'd1: v = 25'sd822227;
      5'd2: v = 25'sd1636536;
      5'd3: v = 25'sd2435084;
      5'd4: v = 25'sd3210181;
      5'd5: v = 25'sd3954362;
      5'd6: v = 25'sd4660461;
      5'd7: v = 25'sd5321677;
      5'd8: v = 25'sd5931642;
      5'd9: v = 25'sd6484482;
      5'd10: v = 25'sd6974873;
      5'd11: v = 25'sd7398092;
      5'd12: v = 25'sd7750063;
      5'd13: v = 25'sd8027397;
      5'd14: v = 25'sd8227423;
      5'd15: v = 25'sd8348215;
      default: v = 25'sd8388608;
    endcase
    return v;
  endfunction

  // ROM entry rounded to Q1.15 (17 bits signed so +1.0 fits)
  function automatic logic signed [TwBits:0] rom_entry(input logic [4:0] idx);
    logic signed [24:0] x;
    x = qsine(idx) + 25'sd128;
    return x[24:8];
  endfunction

  // Twiddle for ROM index k (0..31); inverse flips the sine sign
  function automatic logic signed [2*TwBits+1:0] twiddle(input logic [4:0] k,
                                                           input logic inv);
    logic signed [TwBits:0] c, s;
    if (k <= 5'd16) begin
      c = rom_entry(5'd16 - k);
      s = rom_entry(k);
    end else begin
      c = -rom_entry(k - 5'd16);
      s = rom_entry(5'd0 - k);
    end
    return {c, inv ? s : -s};
  endfunction

  typedef struct packed {
    logic load_we;
    logic bfly_rd;
    logic bfly_wr;
    logic out_rd;
    logic scale;
  } fft_cmd_t;

endpackage

// ----- design/fft_ram.sv -----
// Generic single write, single registered read RAM.
// No dependencies.
module fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- design/fft_ctrl.sv -----
// FFT sequencer: load, butterfly stages, unload with skid-free output hold.
// Depends on fft_pkg.
module fft_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      out_stall,
  output logic                      out_valid,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_idx,
  input  logic [2:0]                cfg_data,
  output logic                      inv_o,
  output logic [2:0]                l_o,
  output logic [fft_pkg::AddrBits-1:0] load_addr_o,
  output logic [fft_pkg::AddrBits-1:0] addr_a_o,
  output logic [fft_pkg::AddrBits-1:0] addr_b_o,
  output logic [4:0]                tw_k_o,
  output logic [fft_pkg::AddrBits-1:0] bin_o,
  output logic                      last_o,
  output fft_pkg::fft_cmd_t         cmd_o
);
  import fft_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_BFLY = 4'b0010,
    S_OUT  = 4'b0100,
    S_WAIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic inv_q, inv_d;
  logic [2:0] len_q, len_d;
  logic [6:0] cnt_q, cnt_d;           // load count
  logic [2:0] stg_q, stg_d;           // butterfly stage
  logic [4:0] bf_q, bf_d;             // butterfly within stage
  logic [1:0] ph_q, ph_d;             // butterfly phase
  logic [6:0] oc_q, oc_d;             // output read pointer
  logic       rdp_q;                  // output read in flight
  logic [6:0] n;
  logic [2:0] l;
  logic [5:0] brev;
  logic [5:0] pos;
  logic [5:0] m, j;
  logic       out_busy;

  // active length
  always_comb begin
    l = (len_q == 3'd0) ? 3'd1 : (len_q > 3'(MaxLog2)) ? 3'(MaxLog2) : len_q;
    n = 7'd1 << l;
  end
  assign inv_o = inv_q;
  assign l_o = l;

  // bit-reversed load address
  always_comb begin
    pos = (cnt_q >= n) ? 6'd0 : cnt_q[5:0];
    brev = '0;
    for (int b = 0; b < MaxLog2; b++) begin
      if (3'(b) < l) brev[3'(l - 3'd1 - 3'(b))] = pos[b];
    end
  end
  assign load_addr_o = brev;

  // butterfly addressing
  always_comb begin
    m = 6'd1 << stg_q;
    j = 6'(bf_q) & (m - 6'd1);
    addr_a_o = ((6'(bf_q) & ~(m - 6'd1)) << 1) | j;
    addr_b_o = addr_a_o | m;
    tw_k_o = 5'((j << (3'd5 - stg_q)));
  end

  // output stage holds data while stalled; a read issues only when no read
  // is in flight and the output register is free by the next cycle
  assign out_busy = out_valid && out_stall;
  assign in_stall = (state_q != S_LOAD);

  always_comb begin
    state_d = state_q;
    inv_d = inv_q;
    len_d = len_q;
    cnt_d = cnt_q;
    stg_d = stg_q;
    bf_d = bf_q;
    ph_d = ph_q;
    oc_d = oc_q;
    cmd_o = '0;
    if (cfg_we) begin
      if (cfg_idx == 1'b0) inv_d = cfg_data[0];
      else len_d = cfg_data;
    end
    case (state_q)
      S_LOAD: begin
        if (in_valid) begin
          cmd_o.load_we = 1'b1;
          if (7'(pos) + 7'd1 >= n) begin
            cnt_d = '0;
            state_d = S_BFLY;
            stg_d = '0;
            bf_d = '0;
            ph_d = '0;
          end else begin
            cnt_d = 7'(pos) + 7'd1;
          end
        end
      end
      S_BFLY: begin
        // phase 0 read, 1 read data valid, 2 product reg, 3 write
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd0) cmd_o.bfly_rd = 1'b1;
        if (ph_q == 2'd3) begin
          cmd_o.bfly_wr = 1'b1;
          if (7'(bf_q) + 7'd1 >= (n >> 1)) begin
            bf_d = '0;
            if (stg_q + 3'd1 >= l) begin
              state_d = S_OUT;
              oc_d = '0;
            end else begin
              stg_d = stg_q + 3'd1;
            end
          end else begin
            bf_d = bf_q + 5'd1;
          end
        end
      end
      S_OUT: begin
        // issue a read when the output register will be free
        if (!out_busy && !rdp_q) begin
          cmd_o.out_rd = 1'b1;
          cmd_o.scale = inv_q;
          oc_d = oc_q + 7'd1;
          if (oc_q + 7'd1 >= n) state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // last beat landed and is being taken
        if (!out_busy && !rdp_q) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end
  assign bin_o = oc_q[5:0];
  assign last_o = (oc_q + 7'd1 >= n);

  // out_valid tracks the datapath output register
  logic ov_q, ov_d;
  always_comb begin
    ov_d = ov_q;
    if (rdp_q) ov_d = 1'b1;
    else if (!out_stall) ov_d = 1'b0;
  end
  assign out_valid = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      inv_q <= 1'b0;
      len_q <= 3'd6;
      cnt_q <= '0;
      stg_q <= '0;
      bf_q <= '0;
      ph_q <= '0;
      oc_q <= '0;
      rdp_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inv_q <= inv_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
      stg_q <= stg_d;
      bf_q <= bf_d;
      ph_q <= ph_d;
      oc_q <= oc_d;
      rdp_q <= cmd_o.out_rd;
      ov_q <= ov_d;
    end
  end
endmodule

// ----- design/fft_dp.sv -----
// FFT datapath: work memories, butterfly unit, inverse scaling, output reg.
// Depends on fft_pkg and fft_ram.
module fft_dp (
  input  logic                      clk_i,
  input  fft_pkg::fft_cmd_t         cmd_i,
  input  logic                      out_stall,
  input  logic                      inv_i,
  input  logic [2:0]                l_i,
  input  logic signed [fft_pkg::SampleBits-1:0] in_re,
  input  logic signed [fft_pkg::SampleBits-1:0] in_im,
  input  logic [fft_pkg::AddrBits-1:0] load_addr_i,
  input  logic [fft_pkg::AddrBits-1:0] addr_a_i,
  input  logic [fft_pkg::AddrBits-1:0] addr_b_i,
  input  logic [4:0]                tw_k_i,
  input  logic [fft_pkg::AddrBits-1:0] bin_i,
  input  logic                      last_i,
  output logic signed [fft_pkg::OutBits-1:0] out_re,
  output logic signed [fft_pkg::OutBits-1:0] out_im,
  output logic [fft_pkg::AddrBits-1:0] bin_o,
  output logic                      last_o
);
  import fft_pkg::*;

  logic we;
  logic [AddrBits-1:0] waddr, raddr_a, raddr_b, addr_a_q, addr_b_q;
  logic [WordBits-1:0] wdata, rd_a, rd_b;
  logic we2;
  logic [WordBits-1:0] wdata2;

  // bank A read port serves butterfly top and output reads;
  // two copies keep two read ports
  assign raddr_a = cmd_i.out_rd ? bin_i : addr_a_i;
  assign raddr_b = addr_b_i;

  // write sequencing: butterfly writes a then b on consecutive cycles
  logic pend_q;
  logic [WordBits-1:0] pend_data_q;
  logic [AddrBits-1:0] pend_addr_q;
  logic signed [OutBits-1:0] ar, ai, br, bi;
  logic signed [2*TwBits+1:0] tw;
  logic signed [TwBits:0] wr, wi;
  logic signed [OutBits+TwBits:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [OutBits+TwBits:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [OutBits+TwBits+1:0] sr, si;
  logic signed [OutBits+TwBits+1:0] tr, ti;
  logic signed [OutBits-1:0] ar_q, ai_q;
  logic signed [OutBits-1:0] na_r, na_i, nb_r, nb_i;
  logic [4:0] twk_q;

  assign ar = rd_a[WordBits-1:OutBits];
  assign ai = rd_a[OutBits-1:0];
  assign br = rd_b[WordBits-1:OutBits];
  assign bi = rd_b[OutBits-1:0];
  assign tw = twiddle(twk_q, inv_i);
  assign wr = tw[2*TwBits+1:TwBits+1];
  assign wi = tw[TwBits:0];

  // products registered in the cycle after read data
  assign p_rr = br * wr;
  assign p_ii = bi * wi;
  assign p_ri = br * wi;
  assign p_ir = bi * wr;
  logic rdv_q, prv_q;

  always_ff @(posedge clk_i) begin
    twk_q <= tw_k_i;
    addr_a_q <= addr_a_i;
    addr_b_q <= addr_b_i;
    if (rdv_q) begin
      p_rr_q <= p_rr;
      p_ii_q <= p_ii;
      p_ri_q <= p_ri;
      p_ir_q <= p_ir;
      ar_q <= ar;
      ai_q <= ai;
    end
  end

  always_comb begin
    sr = (OutBits+TwBits+2)'(p_rr_q) - (OutBits+TwBits+2)'(p_ii_q)
         + (OutBits+TwBits+2)'(1 << (TwBits - 2));
    si = (OutBits+TwBits+2)'(p_ri_q) + (OutBits+TwBits+2)'(p_ir_q)
         + (OutBits+TwBits+2)'(1 << (TwBits - 2));
    tr = sr >>> (TwBits - 1);
    ti = si >>> (TwBits - 1);
    na_r = OutBits'(ar_q + tr[OutBits-1:0]);
    na_i = OutBits'(ai_q + ti[OutBits-1:0]);
    nb_r = OutBits'(ar_q - tr[OutBits-1:0]);
    nb_i = OutBits'(ai_q - ti[OutBits-1:0]);
  end

  // butterfly timing: rd at ph0, data at ph1 (rdv), products at ph2, write at ph3
  logic [AddrBits-1:0] wa_q, wb_q;
  always_ff @(posedge clk_i) begin
    rdv_q <= cmd_i.bfly_rd;
    prv_q <= rdv_q;
    if (cmd_i.bfly_rd) begin
      wa_q <= addr_a_i;
      wb_q <= addr_b_i;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = load_addr_i;
    wdata = {OutBits'(in_re), OutBits'(in_im)};
    if (cmd_i.load_we) begin
      we = 1'b1;
    end else if (cmd_i.bfly_wr) begin
      we = 1'b1;
      waddr = wa_q;
      wdata = {na_r, na_i};
    end else if (pend_q) begin
      we = 1'b1;
      waddr = pend_addr_q;
      wdata = pend_data_q;
    end
  end
  assign we2 = we;
  assign wdata2 = wdata;

  always_ff @(posedge clk_i) begin
    pend_q <= cmd_i.bfly_wr;
    pend_addr_q <= wb_q;
    pend_data_q <= {nb_r, nb_i};
  end

  fft_ram #(.Width(WordBits), .Depth(MaxPoints)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_a), .rdata_o(rd_a)
  );
  fft_ram #(.Width(WordBits), .Depth(MaxPoints)) u_ram_b (
    .clk_i, .we_i(we2), .waddr_i(waddr), .wdata_i(wdata2),
    .raddr_i(raddr_b), .rdata_o(rd_b)
  );

  // output: memory read data passes through the RAM read register into the output register
  logic ord_q, scl_q, lst_q;
  logic [AddrBits-1:0] bin_q;
  logic signed [OutBits:0] rr, ri;
  logic signed [OutBits-1:0] sc_r, sc_i;
  always_comb begin
    rr = (OutBits+1)'(ar) + ((OutBits+1)'(1) << l_i >> 1);
    ri = (OutBits+1)'(ai) + ((OutBits+1)'(1) << l_i >> 1);
    sc_r = scl_q ? OutBits'(rr >>> l_i) : ar;
    sc_i = scl_q ? OutBits'(ri >>> l_i) : ai;
  end
  always_ff @(posedge clk_i) begin
    ord_q <= cmd_i.out_rd;
    scl_q <= cmd_i.scale;
    if (cmd_i.out_rd) begin
      bin_q <= bin_i;
      lst_q <= last_i;
    end
    if (ord_q) begin
      out_re <= sc_r;
      out_im <= sc_i;
      bin_o <= bin_q;
      last_o <= lst_q;
    end
  end
  logic unused;
  assign unused = ^{addr_a_q, addr_b_q, prv_q, out_stall, inv_i};
endmodule

// ----- design/radix2_fft_engine.sv -----
// Top level of the radix-2 DIT FFT engine.
// Depends on fft_pkg, fft_ctrl, fft_dp, fft_ram.
//
// Input channel: in_valid / in_stall carry one complex Q1.15 sample a beat.
// A frame of N = 2^length_log2 samples (2..64) is loaded in time order.
// After the last sample the engine stalls input, runs log2(N) stages of
// N/2 butterflies (one shared butterfly unit and one write port on the
// work memory), then unloads N points in natural order.
// Output channel: out_valid / out_stall, one spectrum point a beat, with
// bin_index and last flag; a new memory read issues only after the
// previous read has landed. The output register holds its beat while the
// receiver stalls; memory reads pause until it is taken.
// Reset clears the sequencer, sets forward mode and length 64; the work
// memory is not cleared. The user must write configuration only while
// idle; the block itself does not enforce it.
module radix2_fft_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_re_i,
  input  logic signed [15:0] in_im_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [21:0] out_re_o,
  output logic signed [21:0] out_im_o,
  output logic [5:0]  bin_index_o,
  output logic        last_o,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [2:0]  cfg_data
);
  import fft_pkg::*;

  fft_cmd_t cmd;
  logic inv;
  logic [2:0] l;
  logic [AddrBits-1:0] load_addr, addr_a, addr_b, bin;
  logic [4:0] tw_k;
  logic lst;

  fft_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_stall, .out_valid,
    .cfg_we, .cfg_idx, .cfg_data, .inv_o(inv), .l_o(l),
    .load_addr_o(load_addr), .addr_a_o(addr_a), .addr_b_o(addr_b),
    .tw_k_o(tw_k), .bin_o(bin), .last_o(lst), .cmd_o(cmd)
  );

  fft_dp u_dp (
    .clk_i, .cmd_i(cmd), .out_stall, .inv_i(inv), .l_i(l),
    .in_re(in_re_i), .in_im(in_im_i), .load_addr_i(load_addr),
    .addr_a_i(addr_a), .addr_b_i(addr_b), .tw_k_i(tw_k), .bin_i(bin),
    .last_i(lst), .out_re(out_re_o), .out_im(out_im_o),
    .bin_o(bin_index_o), .last_o(last_o)
  );

  // no input beat while output is pending
  a_no_in_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input taken during unload");
  // a stalled output beat keeps its bin
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(bin_index_o))
    else $error("output beat lost");
endmodule
